// ===== rtl/core/dxt_pkg.sv =====
// ----------------------------------------------------------------------------
// dxt_pkg
// Shared types, codes and small arithmetic helpers for the block decoder.
// ----------------------------------------------------------------------------
package dxt_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // block format codes, code three decodes as dxt5
    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;

    localparam logic [15:0] RESET_WIDTH  = 16'd256;
    localparam logic [15:0] RESET_HEIGHT = 16'd256;

    // one block after classification, as held in the queue
    typedef struct packed {
        logic               is_dxt1;
        logic               is_dxt3;
        logic               four;       // four-color mode
        logic               a7;         // eight-entry alpha palette
        logic [2:0][7:0]    e0;
        logic [2:0][7:0]    e1;
        logic [2:0][9:0]    n2;
        logic [2:0][9:0]    n3;
        logic [5:0][10:0]   anum;
        logic [63:0]        alpha_word;
        logic [31:0]        cidx;
        logic [13:0]        col;
        logic [13:0]        row;
        logic [2:0]         vc;         // visible texel columns
        logic [2:0]         vr;         // visible texel rows
        logic               final_blk;
    } t_blk_cmd;

    // block with its palettes resolved, held by the texel engine
    typedef struct packed {
        logic               is_dxt1;
        logic               is_dxt3;
        logic               four;
        logic [3:0][2:0][7:0] pal;
        logic [7:0][7:0]    apal;
        logic [63:0]        alpha_word;
        logic [31:0]        cidx;
        logic [13:0]        col;
        logic [13:0]        row;
        logic [2:0]         vc;
        logic [2:0]         vr;
        logic               final_blk;
    } t_blk_pal;

    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last_of_block;
        logic        last_of_image;
    } t_texel;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

    // x*255/31 as 8x + floor(7x/31)
    function automatic logic [7:0] exp5(input logic [4:0] x);
        logic [16:0] p;
        p = 17'(x) * 17'd7 * 17'd265;
        return {x, 3'b000} + 8'(p[15:13]);
    endfunction

    // x*255/63 as 4x + floor(x/21)
    function automatic logic [7:0] exp6(input logic [5:0] x);
        logic [1:0] q;
        if (x >= 6'd63)      q = 2'd3;
        else if (x >= 6'd42) q = 2'd2;
        else if (x >= 6'd21) q = 2'd1;
        else                 q = 2'd0;
        return {x, 2'b00} + 8'(q);
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [20:0] p;
        p = 21'(s) * 21'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] s);
        logic [21:0] p;
        p = 22'(s) * 22'd3277;
        return p[21:14];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] s);
        logic [21:0] p;
        p = 22'(s) * 22'd2341;
        return p[21:14];
    endfunction

    // visible texels along one axis from the signed distance to the edge
    function automatic logic [2:0] crop_count(input logic [16:0] d);
        if (d[16] || d == 17'd0) return 3'd0;
        else if (|d[15:2])       return 3'd4;
        else                     return d[2:0];
    endfunction

endpackage

// ===== rtl/core/dxt_if.sv =====
// ----------------------------------------------------------------------------
// dxt channel interfaces
// Block input, texel output and configuration write channels.
// ----------------------------------------------------------------------------
interface dxt_blk_if;
    logic        valid;
    logic        ready;
    logic [63:0] alpha_word;
    logic [63:0] color_word;
    modport source (output valid, alpha_word, color_word, input ready);
    modport sink   (input valid, alpha_word, color_word, output ready);
endinterface

interface dxt_tex_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last_of_block;
    logic        last_of_image;
    modport source (output valid, pixel_x, pixel_y, red, green, blue, alpha,
                    last_of_block, last_of_image, input ready);
    modport sink   (input valid, pixel_x, pixel_y, red, green, blue, alpha,
                    last_of_block, last_of_image, output ready);
endinterface

interface dxt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/dxt_front.sv =====
// ----------------------------------------------------------------------------
// dxt_front
// Holds configuration and block position, accepts blocks and classifies
// them: color mode, expanded endpoints, interpolation sums and crop counts.
// ----------------------------------------------------------------------------
module dxt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    dxt_cfg_if.sink             i_cfg,
    dxt_blk_if.sink             i_blk,
    input  dxt_pkg::t_q_stat    i_q_stat,
    output logic                o_push,
    output dxt_pkg::t_blk_cmd   o_cmd
);
    import dxt_pkg::*;

    logic [1:0]  r_format;
    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [13:0] r_col, n_col;
    logic [13:0] r_row, n_row;

    logic [15:0] c0, c1;
    logic [7:0]  a0, a1;
    logic        four, a7;
    logic [14:0] blocks_x, blocks_y;
    logic        col_end, row_end;
    logic [2:0][7:0] e0, e1;

    assign i_cfg.ready = 1'b1;
    assign i_blk.ready = !i_q_stat.full;
    assign o_push      = i_blk.valid && !i_q_stat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_DXT1;
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FORMAT: r_format <= i_cfg.data[1:0];
                CFG_WIDTH:  r_width  <= i_cfg.data;
                CFG_HEIGHT: r_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // block position walk
    always_comb begin
        blocks_x = 15'(({1'b0, r_width} + 17'd3) >> 2);
        blocks_y = 15'(({1'b0, r_height} + 17'd3) >> 2);
        col_end  = ({1'b0, r_col} + 15'd1) >= blocks_x;
        row_end  = ({1'b0, r_row} + 15'd1) >= blocks_y;
        n_col    = r_col;
        n_row    = r_row;
        if (o_push) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + 14'd1;
            end else begin
                n_col = r_col + 14'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_comb begin
        c0   = i_blk.color_word[15:0];
        c1   = i_blk.color_word[31:16];
        a0   = i_blk.alpha_word[7:0];
        a1   = i_blk.alpha_word[15:8];
        four = (r_format != FMT_DXT1) || (c0 > c1);
        a7   = a0 > a1;
        e0[0] = exp5(c0[15:11]);
        e0[1] = exp6(c0[10:5]);
        e0[2] = exp5(c0[4:0]);
        e1[0] = exp5(c1[15:11]);
        e1[1] = exp6(c1[10:5]);
        e1[2] = exp5(c1[4:0]);

        o_cmd.is_dxt1 = (r_format == FMT_DXT1);
        o_cmd.is_dxt3 = (r_format == FMT_DXT3);
        o_cmd.four    = four;
        o_cmd.a7      = a7;
        o_cmd.e0      = e0;
        o_cmd.e1      = e1;
        for (int ch = 0; ch < 3; ch++) begin
            o_cmd.n2[ch] = four ? {1'b0, e0[ch], 1'b0} + {2'b00, e1[ch]}
                                : {2'b00, e0[ch]} + {2'b00, e1[ch]};
            o_cmd.n3[ch] = {2'b00, e0[ch]} + {1'b0, e1[ch], 1'b0};
        end
        // weighted alpha sums, the six-entry palette uses fifths
        for (int j = 1; j < 7; j++) begin
            if (a7 || j > 4) begin
                o_cmd.anum[j-1] = 11'(7 - j) * {3'b000, a0} + 11'(j) * {3'b000, a1};
            end else begin
                o_cmd.anum[j-1] = 11'(5 - j) * {3'b000, a0} + 11'(j) * {3'b000, a1};
            end
        end
        o_cmd.alpha_word = i_blk.alpha_word;
        o_cmd.cidx       = i_blk.color_word[63:32];
        o_cmd.col        = r_col;
        o_cmd.row        = r_row;
        o_cmd.vc = crop_count({1'b0, r_width} - {1'b0, r_col, 2'b00});
        o_cmd.vr = crop_count({1'b0, r_height} - {1'b0, r_row, 2'b00});
        o_cmd.final_blk = col_end && row_end;
    end

endmodule

// ===== rtl/core/dxt_queue.sv =====
// ----------------------------------------------------------------------------
// dxt_queue
// Two-entry block queue between the classifying front and the texel engine.
// ----------------------------------------------------------------------------
module dxt_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dxt_pkg::t_blk_cmd   i_cmd,
    input  logic                i_pop,
    output dxt_pkg::t_q_stat    o_stat,
    output dxt_pkg::t_blk_cmd   o_head
);
    import dxt_pkg::*;

    t_blk_cmd   r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_stat.full      = (r_cnt == 2'd2);
    assign o_stat.not_empty = (r_cnt != 2'd0);
    assign o_head           = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

// ===== rtl/core/dxt_back.sv =====
// ----------------------------------------------------------------------------
// dxt_back
// Resolves the palettes of the queue head, then walks its texels one per
// cycle into an output register while that register is not stalled.
// ----------------------------------------------------------------------------
module dxt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dxt_pkg::t_q_stat    i_q_stat,
    input  dxt_pkg::t_blk_cmd   i_head,
    output logic                o_pop,
    dxt_tex_if.source           o_tex
);
    import dxt_pkg::*;

    t_blk_pal   r_slot, n_slot;
    logic       r_slot_valid, n_slot_valid;
    logic [3:0] r_tex, n_tex;
    t_texel     r_out, n_out;
    logic       r_out_valid;

    logic       adv, step, load, emit, done, blk_empty;
    logic [1:0] col, row, ci;
    logic [5:0] aoff;
    logic [2:0] aidx;
    logic [3:0] nib;

    // palette resolve, at most one constant multiply per entry
    always_comb begin
        n_slot.is_dxt1 = i_head.is_dxt1;
        n_slot.is_dxt3 = i_head.is_dxt3;
        n_slot.four    = i_head.four;
        for (int ch = 0; ch < 3; ch++) begin
            n_slot.pal[0][ch] = i_head.e0[ch];
            n_slot.pal[1][ch] = i_head.e1[ch];
            n_slot.pal[2][ch] = i_head.four ? div3(i_head.n2[ch]) : i_head.n2[ch][8:1];
            n_slot.pal[3][ch] = i_head.four ? div3(i_head.n3[ch]) : 8'd0;
        end
        n_slot.apal[0] = i_head.alpha_word[7:0];
        n_slot.apal[1] = i_head.alpha_word[15:8];
        for (int j = 0; j < 4; j++) begin
            n_slot.apal[j+2] = i_head.a7 ? div7(i_head.anum[j]) : div5(i_head.anum[j]);
        end
        n_slot.apal[6]    = i_head.a7 ? div7(i_head.anum[4]) : 8'd0;
        n_slot.apal[7]    = i_head.a7 ? div7(i_head.anum[5]) : 8'hff;
        n_slot.alpha_word = i_head.alpha_word;
        n_slot.cidx       = i_head.cidx;
        n_slot.col        = i_head.col;
        n_slot.row        = i_head.row;
        n_slot.vc         = i_head.vc;
        n_slot.vr         = i_head.vr;
        n_slot.final_blk  = i_head.final_blk;
    end

    // texel walk
    always_comb begin
        col       = r_tex[1:0];
        row       = r_tex[3:2];
        blk_empty = (r_slot.vc == 3'd0) || (r_slot.vr == 3'd0);
        emit      = !blk_empty && ({1'b0, col} < r_slot.vc) && ({1'b0, row} < r_slot.vr);
        done      = blk_empty || ((col == 2'(r_slot.vc - 3'd1)) &&
                                  (row == 2'(r_slot.vr - 3'd1)));
        adv       = !r_out_valid || o_tex.ready;
        step      = r_slot_valid && adv;
        load      = i_q_stat.not_empty && (!r_slot_valid || (step && done));

        ci   = r_slot.cidx[{r_tex, 1'b0} +: 2];
        aoff = 6'd16 + {2'b00, r_tex} + {1'b0, r_tex, 1'b0};
        aidx = r_slot.alpha_word[aoff +: 3];
        nib  = r_slot.alpha_word[{r_tex, 2'b00} +: 4];

        n_out.pixel_x = {r_slot.col, col};
        n_out.pixel_y = {r_slot.row, row};
        n_out.red     = r_slot.pal[ci][0];
        n_out.green   = r_slot.pal[ci][1];
        n_out.blue    = r_slot.pal[ci][2];
        if (r_slot.is_dxt1) begin
            // transparent black in three-color mode
            n_out.alpha = (ci == 2'd3 && !r_slot.four) ? 8'd0 : 8'hff;
        end else if (r_slot.is_dxt3) begin
            n_out.alpha = {nib, nib};
        end else begin
            n_out.alpha = r_slot.apal[aidx];
        end
        n_out.last_of_block = done;
        n_out.last_of_image = done && r_slot.final_blk;

        n_slot_valid = r_slot_valid;
        n_tex        = r_tex;
        if (load) begin
            n_slot_valid = 1'b1;
            n_tex        = '0;
        end else if (step) begin
            n_slot_valid = !done;
            n_tex        = r_tex + 4'd1;
        end
    end

    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= 1'b0;
            r_tex        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_slot_valid <= n_slot_valid;
            r_tex        <= n_tex;
            if (adv) r_out_valid <= step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_slot <= n_slot;
        if (step && emit) r_out <= n_out;
    end

    assign o_tex.valid         = r_out_valid;
    assign o_tex.pixel_x       = r_out.pixel_x;
    assign o_tex.pixel_y       = r_out.pixel_y;
    assign o_tex.red           = r_out.red;
    assign o_tex.green         = r_out.green;
    assign o_tex.blue          = r_out.blue;
    assign o_tex.alpha         = r_out.alpha;
    assign o_tex.last_of_block = r_out.last_of_block;
    assign o_tex.last_of_image = r_out.last_of_image;

endmodule

// ===== rtl/core/dxt_block_texture_decoder.sv =====
// ----------------------------------------------------------------------------
// dxt_block_texture_decoder
// S3TC (DXT1/DXT3/DXT5) block decoder to RGBA8 texels with pixel coordinates.
// ----------------------------------------------------------------------------
// Blocks arrive in raster block order and are accepted into a two-entry
// queue; the texel engine then emits at most one texel per cycle, walking
// the texel positions of a block up to its last visible one, so a full
// block walks all 16 positions, an edge block stops at its last visible
// texel and a block wholly outside the image emits nothing. The texel
// engine sets the sustained rate; a block word passes through the queue,
// the palette slot and the output register before its first texel leaves.
// Configuration writes are always taken and apply to blocks accepted after
// them; the block position is not moved by a write.
module dxt_block_texture_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dxt_cfg_if.sink     i_cfg,
    dxt_blk_if.sink     i_blk,
    dxt_tex_if.source   o_tex
);
    import dxt_pkg::*;

    t_q_stat  q_stat;
    t_blk_cmd push_cmd;
    t_blk_cmd head_cmd;
    logic     push;
    logic     pop;

    dxt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_blk    (i_blk),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    dxt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_head  (head_cmd)
    );

    dxt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_head   (head_cmd),
        .o_pop    (pop),
        .o_tex    (o_tex)
    );

endmodule
